[design/heat_table_scan_engine_defines.svh]
// ----------------------------------------------------------------------------
// Heat table scan engine assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef HEAT_TABLE_SCAN_ENGINE_DEFINES_SVH
`define HEAT_TABLE_SCAN_ENGINE_DEFINES_SVH

// same-cycle implication
`define HTSE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("heat table check failed");

// next-cycle implication
`define HTSE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("heat table check failed");

`endif

[design/htse_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heat table scan engine package
// Field widths, opcodes, status codes and fixed values shared by the design.
// ----------------------------------------------------------------------------
package htse_pkg;

    localparam int LAYERS_DEF = 16;
    localparam int TIMES_DEF  = 256;

    localparam int OP_W     = 3;
    localparam int LAYER_W  = 5;
    localparam int TIME_W   = 9;
    localparam int TEMP_W   = 18;
    localparam int STATUS_W = 2;
    localparam int FOUND_W  = 6;

    typedef logic [OP_W-1:0]            opcode_t;
    typedef logic [LAYER_W-1:0]         layer_t;
    typedef logic [TIME_W-1:0]          time_t;
    typedef logic signed [TEMP_W-1:0]   temp_t;
    typedef logic [STATUS_W-1:0]        status_t;
    typedef logic signed [FOUND_W-1:0]  found_t;

    localparam opcode_t OP_CLEAR_FILL = 3'd0;
    localparam opcode_t OP_CLEAR_ZERO = 3'd1;
    localparam opcode_t OP_WRITE      = 3'd2;
    localparam opcode_t OP_READ       = 3'd3;
    localparam opcode_t OP_LARGEST    = 3'd4;
    localparam opcode_t OP_DEEPEST    = 3'd5;
    localparam opcode_t OP_LAYER_MAX  = 3'd6;
    localparam opcode_t OP_LAYER_USED = 3'd7;

    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_BAD_LAYER = 2'd1;
    localparam status_t ST_BAD_TIME  = 2'd2;
    localparam status_t ST_UNUSED    = 2'd3;

    // -1.0 degree in Q13.4
    localparam temp_t  NEG_ONE_Q4  = -18'sd16;
    localparam temp_t  FILL_RESET  = -18'sd16;
    localparam temp_t  TEMP_ZERO   = 18'sd0;
    localparam found_t FOUND_NONE  = -6'sd1;

endpackage

[design/heat_table_scan_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heat table scan engine
// Layer-by-time temperature table with clear, write, read and scan opcodes.
// ----------------------------------------------------------------------------
// The table sits in one RAM of LAYERS*TIMES entries with a single write and
// a single read port; clears and scans walk it one entry per clock. Items
// are taken one at a time: a write, a read, a layer query (max or used), a
// full-table query (largest, deepest) or a clear finishes before the next
// item is accepted, and a layer query for layer 0 or a bad layer finishes
// without a walk. After reset the block runs a clearing pass over all
// LAYERS*TIMES entries, 4096 at the default size, with item_stall high;
// writes to fill_value are taken at any time. A finished result waits in the
// output register while the next item is accepted.
module heat_table_scan_engine #(
    parameter int LAYERS = htse_pkg::LAYERS_DEF,
    parameter int TIMES  = htse_pkg::TIMES_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    output logic                      item_stall,
    input  htse_pkg::opcode_t         opcode,
    input  htse_pkg::layer_t          layer,
    input  htse_pkg::time_t           time_slot,
    input  htse_pkg::temp_t           value,
    output logic                      result_valid,
    input  logic                      result_stall,
    output htse_pkg::status_t         status,
    output htse_pkg::temp_t           temperature,
    output htse_pkg::found_t          found_layer,
    output logic                      flag,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  htse_pkg::temp_t           fill_value
);

    import htse_pkg::*;

    localparam int DEPTH  = LAYERS * TIMES;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam layer_t             LAST_LAYER = LAYER_W'(LAYERS);
    localparam time_t              LAST_TIME  = TIME_W'(TIMES - 1);
    localparam time_t              TIME_END   = TIME_W'(TIMES);
    localparam logic [ADDR_W-1:0]  LAST_ADDR  = ADDR_W'(DEPTH - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_RD_WAIT,
        S_SCAN,
        S_SCAN_TAIL,
        S_FINISH
    } state_t;

    state_t             state_reg;
    opcode_t            op_reg;
    temp_t              thr_reg;
    temp_t              fill_reg;
    temp_t              lz_reg;
    temp_t              clear_val_reg;
    logic               sweep_result_reg;
    logic [ADDR_W-1:0]  addr_reg;
    layer_t             scan_layer_reg;
    time_t              scan_time_reg;
    logic               layer_scan_reg;
    logic               rd_pending_reg;
    layer_t             rd_layer_reg;

    status_t            res_status_reg;
    temp_t              res_temp_reg;
    found_t             res_found_reg;
    logic               res_flag_reg;

    logic               result_valid_reg;
    status_t            status_reg;
    temp_t              temperature_reg;
    found_t             found_layer_reg;
    logic               flag_reg;

    logic               item_accept;
    logic               layer_ok;
    logic               time_ok;
    layer_t             lay_m1;
    logic [ADDR_W-1:0]  entry_base;
    logic [ADDR_W-1:0]  entry_addr;
    logic               last_issue;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    temp_t              ram_wdata;
    logic [ADDR_W-1:0]  ram_raddr;
    temp_t              ram_rdata;

    assign item_stall   = (state_reg != S_IDLE);
    assign item_accept  = item_valid && !item_stall;
    assign cfg_ready    = 1'b1;

    assign result_valid = result_valid_reg;
    assign status       = status_reg;
    assign temperature  = temperature_reg;
    assign found_layer  = found_layer_reg;
    assign flag         = flag_reg;

    assign layer_ok   = (layer != '0) && (layer <= LAST_LAYER);
    assign time_ok    = (time_slot < TIME_END);
    assign lay_m1     = layer - LAYER_W'(1);
    assign entry_base = ADDR_W'(32'(lay_m1) * TIMES);
    assign entry_addr = entry_base + ADDR_W'(time_slot);
    assign last_issue = (scan_time_reg == LAST_TIME)
                        && (layer_scan_reg || (scan_layer_reg == LAST_LAYER));

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = entry_addr;
        ram_wdata = value;
        ram_raddr = entry_addr;
        case (state_reg)
            S_IDLE:
            begin
                ram_we = item_accept && (opcode == OP_WRITE) && layer_ok && time_ok;
            end
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = addr_reg;
                ram_wdata = clear_val_reg;
            end
            S_SCAN:
            begin
                ram_raddr = addr_reg;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    htse_ram #(
        .WIDTH  (TEMP_W),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_htse_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            op_reg           <= OP_CLEAR_FILL;
            thr_reg          <= TEMP_ZERO;
            fill_reg         <= FILL_RESET;
            lz_reg           <= FILL_RESET;
            clear_val_reg    <= FILL_RESET;
            sweep_result_reg <= 1'b0;
            addr_reg         <= '0;
            scan_layer_reg   <= '0;
            scan_time_reg    <= '0;
            layer_scan_reg   <= 1'b0;
            rd_pending_reg   <= 1'b0;
            rd_layer_reg     <= '0;
            res_status_reg   <= ST_OK;
            res_temp_reg     <= TEMP_ZERO;
            res_found_reg    <= '0;
            res_flag_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            status_reg       <= ST_OK;
            temperature_reg  <= TEMP_ZERO;
            found_layer_reg  <= '0;
            flag_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                fill_reg <= fill_value;
            end

            if (result_valid_reg && !result_stall && (state_reg != S_FINISH))
            begin
                result_valid_reg <= 1'b0;
            end

            // fold the entry read last cycle into the running result
            if (rd_pending_reg && ((state_reg == S_SCAN) || (state_reg == S_SCAN_TAIL)))
            begin
                case (op_reg)
                    OP_LARGEST:
                    begin
                        if (ram_rdata > res_temp_reg)
                        begin
                            res_temp_reg <= ram_rdata;
                        end
                    end
                    OP_DEEPEST:
                    begin
                        if (ram_rdata >= thr_reg)
                        begin
                            res_found_reg <= found_t'({1'b0, rd_layer_reg});
                        end
                    end
                    OP_LAYER_MAX:
                    begin
                        if (ram_rdata >= res_temp_reg)
                        begin
                            res_temp_reg <= ram_rdata;
                        end
                    end
                    OP_LAYER_USED:
                    begin
                        if (ram_rdata != fill_reg)
                        begin
                            res_flag_reg <= 1'b1;
                        end
                    end
                    default:
                    begin
                        res_flag_reg <= res_flag_reg;
                    end
                endcase
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (item_accept)
                    begin
                        op_reg         <= opcode;
                        thr_reg        <= value;
                        res_status_reg <= ST_OK;
                        res_temp_reg   <= TEMP_ZERO;
                        res_found_reg  <= '0;
                        res_flag_reg   <= 1'b0;
                        addr_reg       <= '0;
                        scan_layer_reg <= LAYER_W'(1);
                        scan_time_reg  <= '0;
                        layer_scan_reg <= 1'b0;
                        rd_pending_reg <= 1'b0;
                        case (opcode)
                            OP_CLEAR_FILL:
                            begin
                                clear_val_reg    <= fill_reg;
                                lz_reg           <= fill_reg;
                                sweep_result_reg <= 1'b1;
                                state_reg        <= S_CLEAR;
                            end
                            OP_CLEAR_ZERO:
                            begin
                                clear_val_reg    <= TEMP_ZERO;
                                lz_reg           <= TEMP_ZERO;
                                sweep_result_reg <= 1'b1;
                                state_reg        <= S_CLEAR;
                            end
                            OP_WRITE:
                            begin
                                if (!layer_ok)
                                begin
                                    res_status_reg <= ST_BAD_LAYER;
                                end
                                else if (!time_ok)
                                begin
                                    res_status_reg <= ST_BAD_TIME;
                                end
                                else
                                begin
                                    res_flag_reg <= 1'b1;
                                end
                                state_reg <= S_FINISH;
                            end
                            OP_READ:
                            begin
                                if (!layer_ok)
                                begin
                                    res_status_reg <= ST_BAD_LAYER;
                                    res_temp_reg   <= NEG_ONE_Q4;
                                    state_reg      <= S_FINISH;
                                end
                                else if (!time_ok)
                                begin
                                    res_status_reg <= ST_BAD_TIME;
                                    res_temp_reg   <= NEG_ONE_Q4;
                                    state_reg      <= S_FINISH;
                                end
                                else
                                begin
                                    state_reg <= S_RD_WAIT;
                                end
                            end
                            OP_LARGEST:
                            begin
                                // layer 0 seeds the scan
                                res_temp_reg <= (lz_reg > TEMP_ZERO) ? lz_reg : TEMP_ZERO;
                                state_reg    <= S_SCAN;
                            end
                            OP_DEEPEST:
                            begin
                                res_found_reg <= (lz_reg >= value) ? found_t'(0) : FOUND_NONE;
                                state_reg     <= S_SCAN;
                            end
                            default:
                            begin
                                // layer max and layer used
                                if (layer > LAST_LAYER)
                                begin
                                    res_status_reg <= ST_BAD_LAYER;
                                    state_reg      <= S_FINISH;
                                end
                                else if (layer == '0)
                                begin
                                    if (opcode == OP_LAYER_MAX)
                                    begin
                                        res_temp_reg <= (lz_reg >= NEG_ONE_Q4) ? lz_reg
                                                                               : NEG_ONE_Q4;
                                    end
                                    else
                                    begin
                                        res_flag_reg <= (lz_reg != fill_reg);
                                    end
                                    state_reg <= S_FINISH;
                                end
                                else
                                begin
                                    res_temp_reg   <= (opcode == OP_LAYER_MAX) ? NEG_ONE_Q4
                                                                               : TEMP_ZERO;
                                    addr_reg       <= entry_base;
                                    scan_layer_reg <= layer;
                                    layer_scan_reg <= 1'b1;
                                    state_reg      <= S_SCAN;
                                end
                            end
                        endcase
                    end
                end
                S_CLEAR:
                begin
                    addr_reg <= addr_reg + ADDR_W'(1);
                    if (addr_reg == LAST_ADDR)
                    begin
                        state_reg <= sweep_result_reg ? S_FINISH : S_IDLE;
                    end
                end
                S_RD_WAIT:
                begin
                    res_temp_reg <= ram_rdata;
                    state_reg    <= S_FINISH;
                end
                S_SCAN:
                begin
                    rd_pending_reg <= 1'b1;
                    rd_layer_reg   <= scan_layer_reg;
                    addr_reg       <= addr_reg + ADDR_W'(1);
                    if (scan_time_reg == LAST_TIME)
                    begin
                        scan_time_reg  <= '0;
                        scan_layer_reg <= scan_layer_reg + LAYER_W'(1);
                    end
                    else
                    begin
                        scan_time_reg <= scan_time_reg + TIME_W'(1);
                    end
                    if (last_issue)
                    begin
                        state_reg <= S_SCAN_TAIL;
                    end
                end
                S_SCAN_TAIL:
                begin
                    rd_pending_reg <= 1'b0;
                    state_reg      <= S_FINISH;
                end
                S_FINISH:
                begin
                    // hold until the output register is free
                    if (!result_valid_reg || !result_stall)
                    begin
                        result_valid_reg <= 1'b1;
                        status_reg       <= res_status_reg;
                        temperature_reg  <= res_temp_reg;
                        found_layer_reg  <= res_found_reg;
                        flag_reg         <= res_flag_reg;
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[design/htse_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heat table scan engine RAM
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module htse_ram #(
    parameter int WIDTH  = 18,
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[design/htse_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heat table scan engine checker
// Port-level checks on the scan engine, attached to it by bind.
// ----------------------------------------------------------------------------
`include "heat_table_scan_engine_defines.svh"

module htse_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    input  logic                      item_stall,
    input  htse_pkg::opcode_t         opcode,
    input  htse_pkg::layer_t          layer,
    input  htse_pkg::time_t           time_slot,
    input  htse_pkg::temp_t           value,
    input  logic                      result_valid,
    input  logic                      result_stall,
    input  htse_pkg::status_t         status,
    input  htse_pkg::temp_t           temperature,
    input  htse_pkg::found_t          found_layer,
    input  logic                      flag,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  htse_pkg::temp_t           fill_value
);

    import htse_pkg::*;

    logic item_transfer;

    assign item_transfer = item_valid && !item_stall;

    // one item in flight: a transfer closes the input until its work is done
    `HTSE_ASSERT_NEXT(a_one_in_flight, item_transfer, item_stall)

    // no status code beyond the three in use (ok, bad layer, bad time)
    `HTSE_ASSERT_NOW(a_status_known, result_valid, status != ST_UNUSED)

    // a raised flag never comes with an error status
    `HTSE_ASSERT_NOW(a_flag_ok, result_valid && flag, status == ST_OK)

    // a stalled result holds
    `HTSE_ASSERT_NEXT(a_result_hold, result_valid && result_stall,
        result_valid && $stable(status) && $stable(temperature)
        && $stable(found_layer) && $stable(flag))

endmodule

bind heat_table_scan_engine htse_checker u_htse_checker (.*);
